// ----- rtl/core/mms_pkg.sv -----
// Shared definitions for the motor mode supervisor: event, mode and ack codes,
// limits, the divide-by-10000 reciprocal and the stage record between the two stages.
// No dependencies.
package mms_pkg;

    // event codes carried in the input tuser
    localparam logic [2:0] REQ_REF    = 3'd0;
    localparam logic [2:0] REQ_LIMITS = 3'd1;
    localparam logic [2:0] REQ_ENABLE = 3'd2;
    localparam logic [2:0] REQ_STOP   = 3'd3;
    localparam logic [2:0] REQ_TICK   = 3'd4;
    localparam logic [2:0] REQ_PWM    = 3'd5;

    // supervisor modes
    localparam logic [1:0] MODE_CTRL    = 2'd0;
    localparam logic [1:0] MODE_TIMEOUT = 2'd1;
    localparam logic [1:0] MODE_SAFE    = 2'd2;

    // acknowledgement kinds
    localparam logic [1:0] ACK_REF    = 2'd0;
    localparam logic [1:0] ACK_LIMITS = 2'd1;
    localparam logic [1:0] ACK_ENABLE = 2'd2;

    // what the output stage does with the duty registers
    localparam logic [1:0] DUTY_KEEP    = 2'd0;
    localparam logic [1:0] DUTY_NEUTRAL = 2'd1;
    localparam logic [1:0] DUTY_CALC    = 2'd2;

    // configuration register indexes
    localparam logic CFG_NEUTRAL = 1'b0;
    localparam logic CFG_TICKS   = 1'b1;

    localparam logic [13:0] NEUTRAL_RST = 14'd1842;
    localparam logic [15:0] TICKS_RST   = 16'd5000;

    // speed limit magnitude
    localparam logic signed [15:0] LIMIT_ABS = 16'sd8000;

    // floor(x / RPM_FULL) = (x * RECIP) >> RECIP_SHIFT, exact for x below 2^27
    localparam int unsigned RPM_FULL    = 10000;
    localparam int unsigned RECIP_SHIFT = 41;
    localparam longint unsigned RECIP_L =
        ((64'd1 << RECIP_SHIFT) + 64'(RPM_FULL) - 64'd1) / 64'(RPM_FULL);
    localparam logic [27:0] RECIP = RECIP_L[27:0];

    // record handed from the event stage to the output stage
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] speed_l;
        logic signed [15:0] speed_r;
        logic               ack_valid;
        logic [1:0]         ack_kind;
        logic               ack_ok;
        logic [1:0]         duty_op;
        logic signed [27:0] prod_l;
        logic signed [27:0] prod_r;
    } t_stage;

endpackage

// ----- rtl/core/mms_event.sv -----
// Event stage: holds the supervisor state (mode, speeds, limits, timeout) and
// turns each accepted event into a stage record. Depends on mms_pkg.
module mms_event (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_drain,
    input  logic [2:0]          i_req,
    input  logic signed [15:0]  i_value_a,
    input  logic signed [15:0]  i_value_b,
    input  logic [13:0]         i_neutral,
    input  logic [15:0]         i_ticks,
    output logic                o_valid,
    output mms_pkg::t_stage     o_stage
);
    import mms_pkg::*;

    logic [1:0]         r_mode,    n_mode;
    logic signed [15:0] r_speed_l, n_speed_l;
    logic signed [15:0] r_speed_r, n_speed_r;
    logic signed [13:0] r_lim_lo,  n_lim_lo;
    logic signed [13:0] r_lim_hi,  n_lim_hi;
    logic [15:0]        r_cnt,     n_cnt;
    logic               r_run,     n_run;
    logic               r_valid;
    t_stage             r_stage,   n_stage;

    logic signed [15:0] lo16, hi16;
    logic signed [15:0] clamp_l, clamp_r;
    logic signed [28:0] prod_l, prod_r;
    logic [16:0]        cnt_inc;
    logic               lim_ok;

    // clamp of the stored speeds against the current limits
    always_comb begin
        lo16 = $signed({{2{r_lim_lo[13]}}, r_lim_lo});
        hi16 = $signed({{2{r_lim_hi[13]}}, r_lim_hi});
        clamp_l = r_speed_l;
        if (clamp_l > hi16) clamp_l = hi16;
        if (clamp_l < lo16) clamp_l = lo16;
        clamp_r = r_speed_r;
        if (clamp_r > hi16) clamp_r = hi16;
        if (clamp_r < lo16) clamp_r = lo16;
    end

    // clamped speeds stay within the limit range, so 14 bits carry them
    assign prod_l = $signed({1'b0, i_neutral}) * $signed(clamp_l[13:0]);
    assign prod_r = $signed({1'b0, i_neutral}) * $signed(clamp_r[13:0]);

    assign cnt_inc = {1'b0, r_cnt} + 17'd1;
    assign lim_ok  = (i_value_a >= -LIMIT_ABS) && (i_value_b <= LIMIT_ABS) &&
                     (i_value_a <= i_value_b) && (i_value_a <= 16'sd0) &&
                     (i_value_b >= 16'sd0);

    // event decode and next state
    always_comb begin
        n_mode    = r_mode;
        n_speed_l = r_speed_l;
        n_speed_r = r_speed_r;
        n_lim_lo  = r_lim_lo;
        n_lim_hi  = r_lim_hi;
        n_cnt     = r_cnt;
        n_run     = r_run;
        n_stage.ack_valid = 1'b0;
        n_stage.ack_kind  = ACK_REF;
        n_stage.ack_ok    = 1'b0;
        n_stage.duty_op   = DUTY_KEEP;
        n_stage.prod_l    = prod_l[27:0];
        n_stage.prod_r    = prod_r[27:0];

        case (i_req)
            REQ_REF: begin
                n_stage.ack_valid = 1'b1;
                n_stage.ack_kind  = ACK_REF;
                if (r_mode != MODE_SAFE) begin
                    n_cnt  = '0;
                    n_run  = 1'b1;
                    n_stage.ack_ok = 1'b1;
                    if (r_mode == MODE_TIMEOUT) n_mode = MODE_CTRL;
                    n_speed_l = i_value_a;
                    n_speed_r = i_value_b;
                end
            end
            REQ_LIMITS: begin
                n_stage.ack_valid = 1'b1;
                n_stage.ack_kind  = ACK_LIMITS;
                if (lim_ok) begin
                    n_lim_lo = i_value_a[13:0];
                    n_lim_hi = i_value_b[13:0];
                    n_stage.ack_ok = 1'b1;
                end
            end
            REQ_ENABLE: begin
                n_stage.ack_valid = 1'b1;
                n_stage.ack_kind  = ACK_ENABLE;
                if (r_mode == MODE_SAFE) begin
                    n_mode    = MODE_CTRL;
                    n_speed_l = '0;
                    n_speed_r = '0;
                    n_cnt     = '0;
                    n_run     = 1'b1;
                    n_stage.ack_ok = 1'b1;
                end
            end
            REQ_STOP: begin
                if (r_mode != MODE_SAFE) begin
                    n_mode    = MODE_SAFE;
                    n_speed_l = '0;
                    n_speed_r = '0;
                    n_stage.duty_op = DUTY_NEUTRAL;
                end
            end
            REQ_TICK: begin
                // one-shot timer: stops and clears on expiry
                if (r_run) begin
                    if (cnt_inc >= {1'b0, i_ticks}) begin
                        n_run = 1'b0;
                        n_cnt = '0;
                        if (r_mode == MODE_CTRL) n_mode = MODE_TIMEOUT;
                    end else begin
                        n_cnt = cnt_inc[15:0];
                    end
                end
            end
            REQ_PWM: begin
                if (r_mode == MODE_CTRL) begin
                    n_speed_l = clamp_l;
                    n_speed_r = clamp_r;
                    n_stage.duty_op = DUTY_CALC;
                end else begin
                    n_speed_l = '0;
                    n_speed_r = '0;
                    n_stage.duty_op = DUTY_NEUTRAL;
                end
            end
            default: begin
            end
        endcase

        n_stage.mode    = n_mode;
        n_stage.speed_l = n_speed_l;
        n_stage.speed_r = n_speed_r;
    end

    // state and stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_CTRL;
            r_speed_l <= '0;
            r_speed_r <= '0;
            r_lim_lo  <= -LIMIT_ABS[13:0];
            r_lim_hi  <= LIMIT_ABS[13:0];
            r_cnt     <= '0;
            r_run     <= 1'b1;
            r_valid   <= 1'b0;
        end else begin
            if (i_fire) begin
                r_mode    <= n_mode;
                r_speed_l <= n_speed_l;
                r_speed_r <= n_speed_r;
                r_lim_lo  <= n_lim_lo;
                r_lim_hi  <= n_lim_hi;
                r_cnt     <= n_cnt;
                r_run     <= n_run;
                r_valid   <= 1'b1;
            end else if (i_drain) begin
                r_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

    // stopped timer always sits at zero
    a_timer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run |-> (r_cnt == '0))
        else $error("timeout count nonzero while timer stopped");

    // stored limits bracket zero and stay within the limit magnitude
    a_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lim_lo <= 14'sd0) && (r_lim_hi >= 14'sd0) &&
        (lo16 >= -LIMIT_ABS) && (hi16 <= LIMIT_ABS))
        else $error("speed limits out of range");

    // duty computation only leaves the event stage in controlled mode
    a_calc_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_stage.duty_op == DUTY_CALC)) |-> (r_stage.mode == MODE_CTRL))
        else $error("duty computation outside controlled mode");

endmodule

// ----- rtl/core/mms_duty.sv -----
// Output stage: divides the registered duty products by 10000 (floor) through a
// reciprocal multiply, keeps the duty registers and holds the result. Depends on mms_pkg.
module mms_duty (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_taken,
    input  mms_pkg::t_stage     i_stage,
    input  logic [13:0]         i_neutral,
    output logic                o_valid,
    output logic [1:0]          o_mode,
    output logic [14:0]         o_duty_l,
    output logic [14:0]         o_duty_r,
    output logic signed [15:0]  o_speed_l,
    output logic signed [15:0]  o_speed_r,
    output logic                o_ack_valid,
    output logic [1:0]          o_ack_kind,
    output logic                o_ack_ok
);
    import mms_pkg::*;

    // neutral + floor(p / 10000); negative products round toward minus infinity
    function automatic logic [14:0] duty_of(input logic signed [27:0] p,
                                            input logic [13:0] n);
        logic        neg;
        logic [27:0] pneg;
        logic [26:0] mag;
        logic [54:0] full;
        logic [13:0] q;
        neg  = p[27];
        pneg = -p;
        mag  = neg ? (pneg[26:0] + 27'(RPM_FULL - 1)) : p[26:0];
        full = 55'(mag) * 55'(RECIP);
        q    = full[RECIP_SHIFT +: 14];
        return neg ? ({1'b0, n} - {1'b0, q}) : ({1'b0, n} + {1'b0, q});
    endfunction

    logic               r_valid;
    logic [14:0]        r_duty_l, r_duty_r;
    logic [14:0]        n_duty_l, n_duty_r;
    logic [1:0]         r_mode;
    logic signed [15:0] r_speed_l, r_speed_r;
    logic               r_ack_valid, r_ack_ok;
    logic [1:0]         r_ack_kind;

    // duty update select
    always_comb begin
        n_duty_l = r_duty_l;
        n_duty_r = r_duty_r;
        case (i_stage.duty_op)
            DUTY_NEUTRAL: begin
                n_duty_l = {1'b0, i_neutral};
                n_duty_r = {1'b0, i_neutral};
            end
            DUTY_CALC: begin
                n_duty_l = duty_of(i_stage.prod_l, i_neutral);
                n_duty_r = duty_of(i_stage.prod_r, i_neutral);
            end
            default: begin
            end
        endcase
    end

    // duty registers are state and reset to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_duty_l <= '0;
            r_duty_r <= '0;
        end else begin
            if (i_load) begin
                r_valid  <= 1'b1;
                r_duty_l <= n_duty_l;
                r_duty_r <= n_duty_r;
            end else if (i_taken) begin
                r_valid  <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mode      <= i_stage.mode;
            r_speed_l   <= i_stage.speed_l;
            r_speed_r   <= i_stage.speed_r;
            r_ack_valid <= i_stage.ack_valid;
            r_ack_kind  <= i_stage.ack_kind;
            r_ack_ok    <= i_stage.ack_ok;
        end
    end

    assign o_valid     = r_valid;
    assign o_mode      = r_mode;
    assign o_duty_l    = r_duty_l;
    assign o_duty_r    = r_duty_r;
    assign o_speed_l   = r_speed_l;
    assign o_speed_r   = r_speed_r;
    assign o_ack_valid = r_ack_valid;
    assign o_ack_kind  = r_ack_kind;
    assign o_ack_ok    = r_ack_ok;

endmodule

// ----- rtl/core/motor_mode_supervisor.sv -----
// Motor mode supervisor top level: stream ports, configuration registers and the
// two pipeline stages. Depends on mms_pkg, mms_event and mms_duty.
//
// Takes one event per clock and returns one result per event, in order, from the
// output stage registers. The event stage updates mode, speeds, limits and the
// timeout in the cycle of acceptance and registers the duty products; the output
// stage finishes the divide by 10000 with a reciprocal multiply and holds the result.
// Both stages stall only when the result is not taken, so with the result side ready
// the rate is one event per cycle. Configuration writes are meant for an idle block.
module motor_mode_supervisor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    // event stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value_a[15:0], value_b[31:16]
    input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // mode[1:0], duty_left[16:2], duty_right[31:17],
                                        // speed_left[47:32], speed_right[63:48]
    output logic [3:0]  m_axis_tuser    // ack_valid[0], ack_kind[2:1], ack_ok[3]
);
    import mms_pkg::*;

    logic [13:0]        r_neutral;
    logic [15:0]        r_ticks;
    logic               a_valid, o_en, a_en, fire, a_to_o;
    t_stage             stage;
    logic [1:0]         mode;
    logic [14:0]        duty_l, duty_r;
    logic signed [15:0] speed_l, speed_r;
    logic               ack_valid, ack_ok;
    logic [1:0]         ack_kind;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neutral <= NEUTRAL_RST;
            r_ticks   <= TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_NEUTRAL: r_neutral <= i_cfg_data[13:0];
                CFG_TICKS:   r_ticks   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // pipeline flow control
    assign o_en   = !m_axis_tvalid || m_axis_tready;
    assign a_en   = !a_valid || o_en;
    assign a_to_o = a_valid && o_en;
    assign fire   = s_axis_tvalid && a_en;
    assign s_axis_tready = a_en;

    mms_event u_event (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_drain   (a_to_o),
        .i_req     (s_axis_tuser),
        .i_value_a ($signed(s_axis_tdata[15:0])),
        .i_value_b ($signed(s_axis_tdata[31:16])),
        .i_neutral (r_neutral),
        .i_ticks   (r_ticks),
        .o_valid   (a_valid),
        .o_stage   (stage)
    );

    mms_duty u_duty (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (a_to_o),
        .i_taken     (m_axis_tready),
        .i_stage     (stage),
        .i_neutral   (r_neutral),
        .o_valid     (m_axis_tvalid),
        .o_mode      (mode),
        .o_duty_l    (duty_l),
        .o_duty_r    (duty_r),
        .o_speed_l   (speed_l),
        .o_speed_r   (speed_r),
        .o_ack_valid (ack_valid),
        .o_ack_kind  (ack_kind),
        .o_ack_ok    (ack_ok)
    );

    assign m_axis_tdata = {speed_r, speed_l, duty_r, duty_l, mode};
    assign m_axis_tuser = {ack_ok, ack_kind, ack_valid};

    // the event side stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("event side stalled without result backpressure");

endmodule
